// File: sv/ipu_pkg.sv
`timescale 1ns / 1ps
// ipu_pkg: shared constants, types and codes for the pixel replication upscaler.
// Used by ipu_seq and integer_pixel_replication_upscaler; depends on nothing.
package ipu_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int FILL_W    = $clog2(MAX_WIDTH + 1);
	localparam int SCALE_W   = 7;
	localparam int WIDTH_W   = 12;
	localparam int PIX_W     = 24;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	typedef enum logic [1:0] {
		KIND_PIXEL     = 2'd0,
		KIND_PAD       = 2'd1,
		KIND_NOT_READY = 2'd2
	} kind_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		kind_t             kind;
		logic              row_end;
		logic              line_done;
	} seq_ctl_t;

endpackage

// File: sv/ipu_seq.sv
`timescale 1ns / 1ps
// ipu_seq: fill / replication / padding sequencer of the upscaler.
// Holds the row counters and decides store access and result codes per beat; uses ipu_pkg.
module ipu_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          func,
	input  logic [ipu_pkg::SCALE_W-1:0]   scale,
	input  logic [ipu_pkg::WIDTH_W-1:0]   in_width,
	output ipu_pkg::seq_ctl_t             ctl
);

	logic [ipu_pkg::FILL_W-1:0]  fill_q, fill_d;
	logic [ipu_pkg::ADDR_W-1:0]  col_q, col_d;
	logic [ipu_pkg::SCALE_W-1:0] hrep_q, hrep_d;
	logic [ipu_pkg::SCALE_W-1:0] vrep_q, vrep_d;
	logic [1:0]                  pidx_q, pidx_d;
	logic                        inpad_q, inpad_d;

	logic [ipu_pkg::FILL_W-1:0]  eff_w;
	logic [ipu_pkg::SCALE_W-1:0] eff_s;
	logic [3:0]                  pad_prod;
	logic [2:0]                  pad;
	logic                        full;

	always_comb begin
		if (in_width == '0) begin
			eff_w = ipu_pkg::FILL_W'(1);
		end else if (in_width > ipu_pkg::WIDTH_W'(ipu_pkg::MAX_WIDTH)) begin
			eff_w = ipu_pkg::FILL_W'(ipu_pkg::MAX_WIDTH);
		end else begin
			eff_w = ipu_pkg::FILL_W'(in_width);
		end
		eff_s    = (scale == '0) ? ipu_pkg::SCALE_W'(1) : scale;
		pad_prod = eff_w[1:0] * eff_s[1:0];
		pad      = {1'b0, pad_prod[1:0]};
		full     = (fill_q >= eff_w);
	end

	always_comb begin
		fill_d  = fill_q;
		col_d   = col_q;
		hrep_d  = hrep_q;
		vrep_d  = vrep_q;
		pidx_d  = pidx_q;
		inpad_d = inpad_q;

		ctl           = '0;
		ctl.kind      = ipu_pkg::KIND_NOT_READY;
		ctl.wr_addr   = fill_q[ipu_pkg::ADDR_W-1:0];
		ctl.rd_addr   = col_q;

		if (accept) begin
			if (!func) begin
				if (!full) begin
					ctl.wr_en = 1'b1;
					fill_d    = fill_q + 1'b1;
				end
			end else if (full) begin
				if (inpad_q) begin
					ctl.kind = ipu_pkg::KIND_PAD;
					if ({1'b0, pidx_q} + 3'd1 >= pad) begin
						ctl.row_end = 1'b1;
					end else begin
						pidx_d = pidx_q + 2'd1;
					end
				end else begin
					ctl.kind  = ipu_pkg::KIND_PIXEL;
					ctl.rd_en = 1'b1;
					if ({1'b0, hrep_q} + 8'd1 < {1'b0, eff_s}) begin
						hrep_d = hrep_q + 1'b1;
					end else begin
						hrep_d = '0;
						if (ipu_pkg::FILL_W'(col_q) + 1'b1 < eff_w) begin
							col_d = col_q + 1'b1;
						end else if (pad == '0) begin
							ctl.row_end = 1'b1;
						end else begin
							inpad_d = 1'b1;
							pidx_d  = '0;
						end
					end
				end

				if (ctl.row_end) begin
					col_d   = '0;
					hrep_d  = '0;
					pidx_d  = '0;
					inpad_d = 1'b0;
					if ({1'b0, vrep_q} + 8'd1 >= {1'b0, eff_s}) begin
						ctl.line_done = 1'b1;
						vrep_d        = '0;
						fill_d        = '0;
					end else begin
						vrep_d = vrep_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			col_q   <= '0;
			hrep_q  <= '0;
			vrep_q  <= '0;
			pidx_q  <= '0;
			inpad_q <= 1'b0;
		end else begin
			fill_q  <= fill_d;
			col_q   <= col_d;
			hrep_q  <= hrep_d;
			vrep_q  <= vrep_d;
			pidx_q  <= pidx_d;
			inpad_q <= inpad_d;
		end
	end

endmodule

// File: sv/integer_pixel_replication_upscaler.sv
`timescale 1ns / 1ps
// integer_pixel_replication_upscaler: top level with line store, result register
// and register port; uses ipu_pkg and ipu_seq.
//
// Input channel (in_valid / in_stall): func 0 writes one pixel into the line store,
// func 1 pulls the next result. Write beats give no result; write beats past a
// full row are dropped. A pull before the row is full returns a not-ready beat.
// Once in_width pixels are stored, pulls return the row scale times: each pixel
// repeated scale times, then (width*scale) mod 4 zero padding beats, row_end on
// the last beat of each row and line_done on the last beat of the final row,
// after which the store takes the next row.
// Output channel (out_valid / out_stall): one beat per pull, in the cycle after the
// pull is accepted, read from the single-port line store through a registered read.
// One beat in per cycle, one beat out per cycle; a held output beat stalls the
// input only while out_stall is high.
// Reset clears all counters and the result register; scale and in_width reset to
// 1. Store contents are undefined until written; no clearing pass is needed.
// Registers: scale at 0x0, in_width at 0x4; write only while the block is idle.
module integer_pixel_replication_upscaler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [7:0]                    blue_in,
	input  logic [7:0]                    green_in,
	input  logic [7:0]                    red_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [7:0]                    blue_out,
	output logic [7:0]                    green_out,
	output logic [7:0]                    red_out,
	output logic                          row_end,
	output logic                          line_done,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ipu_pkg::PADDR_W-1:0]   paddr,
	input  logic [ipu_pkg::PDATA_W-1:0]   pwdata,
	output logic [ipu_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [ipu_pkg::SCALE_W-1:0] scale_q;
	logic [ipu_pkg::WIDTH_W-1:0] width_q;

	logic                        accept;
	ipu_pkg::seq_ctl_t           ctl;

	logic [ipu_pkg::PIX_W-1:0]   mem [ipu_pkg::MAX_WIDTH];
	logic [ipu_pkg::PIX_W-1:0]   rd_q;

	logic                        out_valid_q;
	ipu_pkg::kind_t              kind_q;
	logic                        row_end_q;
	logic                        line_done_q;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= ipu_pkg::SCALE_W'(1);
			width_q <= ipu_pkg::WIDTH_W'(1);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				ipu_pkg::REG_SCALE: scale_q <= pwdata[ipu_pkg::SCALE_W-1:0];
				ipu_pkg::REG_WIDTH: width_q <= pwdata[ipu_pkg::WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ipu_pkg::REG_SCALE: prdata = ipu_pkg::PDATA_W'(scale_q);
			ipu_pkg::REG_WIDTH: prdata = ipu_pkg::PDATA_W'(width_q);
			default:            prdata = '0;
		endcase
	end

	// sequencer
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	ipu_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (func),
		.scale    (scale_q),
		.in_width (width_q),
		.ctl      (ctl)
	);

	// line store
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= {red_in, green_in, blue_in};
		end
		if (ctl.rd_en) begin
			rd_q <= mem[ctl.rd_addr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= ipu_pkg::KIND_NOT_READY;
			row_end_q   <= 1'b0;
			line_done_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= func;
			if (func) begin
				kind_q      <= ctl.kind;
				row_end_q   <= ctl.row_end;
				line_done_q <= ctl.line_done;
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign row_end   = row_end_q;
	assign line_done = line_done_q;
	assign blue_out  = (kind_q == ipu_pkg::KIND_PIXEL) ? rd_q[7:0]   : 8'h00;
	assign green_out = (kind_q == ipu_pkg::KIND_PIXEL) ? rd_q[15:8]  : 8'h00;
	assign red_out   = (kind_q == ipu_pkg::KIND_PIXEL) ? rd_q[23:16] : 8'h00;

	// checks
	a_store_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.wr_en && ctl.rd_en))
		else $error("line store written and read in one cycle");

	a_pull_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func) |=> out_valid)
		else $error("accepted pull produced no output beat");

	a_done_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_done) |-> (row_end && kind != ipu_pkg::KIND_NOT_READY))
		else $error("line_done without row_end");

endmodule
